// ===== sv/skvt_pkg.sv =====
// types, codes and constants shared by the sorted key/value table
// no dependencies
package skvt_pkg;

   localparam int SKVT_CAPACITY = 32;
   localparam int SKVT_HELD_W = 6;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_SEARCH = 3'd2,
      ACT_EDIT   = 3'd3,
      ACT_LIST   = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_DUP     = 3'd2,
      ST_MISSING = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_EDIT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] part_key;
      logic signed [31:0] new_quantity;
   } req_word_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [31:0]       entry_key;
      logic signed [31:0]       entry_quantity;
      logic [SKVT_HELD_W-1:0]   entries_held;
      logic                     last_result;
   } rsp_word_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] key;
      logic signed [31:0] quantity;
   } cell_cmd_type;

   typedef struct packed {
      logic               valid;
      logic               less;
      logic signed [31:0] key;
      logic signed [31:0] quantity;
   } cell_link_type;

endpackage

// ===== sv/skvt_cell.sv =====
// one table cell: holds an entry, compares it with the broadcast key and
// shifts to or from its neighbors; depends on skvt_pkg
module skvt_cell
   import skvt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  cell_link_type head,
   input  cell_link_type prev,
   input  cell_link_type next,
   output cell_link_type self,
   output logic          match
);

   logic               valid_ff, valid_in;
   logic signed [31:0] key_ff, key_in;
   logic signed [31:0] quantity_ff, quantity_in;
   logic               less;

   assign less  = valid_ff && (key_ff < cmd.key);
   assign match = valid_ff && (key_ff == cmd.key);

   assign self.valid    = valid_ff;
   assign self.less     = less;
   assign self.key      = key_ff;
   assign self.quantity = quantity_ff;

   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      quantity_in = quantity_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!less) begin
               if (prev.less) begin
                  valid_in    = 1'b1;
                  key_in      = cmd.key;
                  quantity_in = cmd.quantity;
               end else begin
                  valid_in    = prev.valid;
                  key_in      = prev.key;
                  quantity_in = prev.quantity;
               end
            end
         end
         CELL_DELETE: begin
            if (!less) begin
               valid_in    = next.valid;
               key_in      = next.key;
               quantity_in = next.quantity;
            end
         end
         CELL_EDIT: begin
            if (match) begin
               quantity_in = cmd.quantity;
            end
         end
         CELL_ROTATE: begin
            if (valid_ff) begin
               if (next.valid) begin
                  key_in      = next.key;
                  quantity_in = next.quantity;
               end else begin
                  key_in      = head.key;
                  quantity_in = head.quantity;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff      <= key_in;
      quantity_ff <= quantity_in;
   end

endmodule

// ===== sv/sorted_key_value_table.sv =====
// sorted key/value table: a chain of compare-and-shift cells plus control
// depends on skvt_pkg and skvt_cell
//
//   port group   dir  handshake                 word
//   req_word     in   start high, busy low      action, part_key, new_quantity
//   rsp_word     out  rsp_strobe, one cycle     status, key, quantity, held, last
//
// insert, delete, search and edit answer without busy; the result appears the cycle
// after the word is taken and busy stays low
// list holds busy while it rotates the cell chain once around, emitting cell zero
// each cycle; an empty list answers with status empty and does not raise busy
// reset clears the cell valid bits and the entry count
// results cannot be stalled
module sorted_key_value_table
   import skvt_pkg::*;
#(
   parameter int CAPACITY = SKVT_CAPACITY
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      remain_ff, remain_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   cell_cmd_type       cmd;
   cell_link_type      links [CAPACITY+1];
   cell_link_type      tail;
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] valid_vec;
   logic               accept;
   logic               hit;
   logic               full;
   logic signed [31:0] found_quantity;
   logic [6:0]         held_wide;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff == S_LIST);
   assign hit    = |match_vec;
   assign full   = (count_ff == CW'(CAPACITY));

   // chain ends
   assign links[0].valid    = 1'b0;
   assign links[0].less     = 1'b1;
   assign links[0].key      = '0;
   assign links[0].quantity = '0;
   assign tail.valid        = 1'b0;
   assign tail.less         = 1'b0;
   assign tail.key          = '0;
   assign tail.quantity     = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      cell_link_type nxt;
      if (g == CAPACITY - 1) begin : g_last
         assign nxt = tail;
      end else begin : g_inner
         assign nxt = links[g+2];
      end
      skvt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .head  (links[1]),
         .prev  (links[g]),
         .next  (nxt),
         .self  (links[g+1]),
         .match (match_vec[g])
      );
      assign valid_vec[g] = links[g+1].valid;
   end

   always_comb begin
      found_quantity = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            found_quantity = found_quantity | links[i+1].quantity;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      cmd.op        = CELL_HOLD;
      cmd.key       = req_word.part_key;
      cmd.quantity  = req_word.new_quantity;
      held_wide     = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_word_in.entry_key      = req_word.part_key;
               rsp_word_in.entry_quantity = '0;
               rsp_word_in.last_result    = 1'b1;
               rsp_word_in.status         = ST_OK;
               case (req_word.action)
                  ACT_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_word_in.status = ST_FULL;
                     end else if (hit) begin
                        rsp_word_in.status = ST_DUP;
                     end else begin
                        cmd.op                     = CELL_INSERT;
                        count_in                   = count_ff + CW'(1);
                        rsp_word_in.entry_quantity = req_word.new_quantity;
                     end
                  end
                  ACT_DELETE: begin
                     rsp_strobe_in = 1'b1;
                     if (!hit) begin
                        rsp_word_in.status = ST_MISSING;
                     end else begin
                        cmd.op                     = CELL_DELETE;
                        count_in                   = count_ff - CW'(1);
                        rsp_word_in.entry_quantity = found_quantity;
                     end
                  end
                  ACT_SEARCH: begin
                     rsp_strobe_in = 1'b1;
                     if (!hit) begin
                        rsp_word_in.status = ST_MISSING;
                     end else begin
                        rsp_word_in.entry_quantity = found_quantity;
                     end
                  end
                  ACT_EDIT: begin
                     rsp_strobe_in = 1'b1;
                     if (!hit) begin
                        rsp_word_in.status = ST_MISSING;
                     end else begin
                        cmd.op                     = CELL_EDIT;
                        rsp_word_in.entry_quantity = req_word.new_quantity;
                     end
                  end
                  ACT_LIST: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in           = 1'b1;
                        rsp_word_in.status      = ST_EMPTY;
                        rsp_word_in.entry_key   = '0;
                     end else begin
                        state_in  = S_LIST;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LIST: begin
            cmd.op                     = CELL_ROTATE;
            rsp_strobe_in              = 1'b1;
            rsp_word_in.status         = ST_OK;
            rsp_word_in.entry_key      = links[1].key;
            rsp_word_in.entry_quantity = links[1].quantity;
            rsp_word_in.last_result    = (remain_ff == CW'(1));
            remain_in                  = remain_ff - CW'(1);
            if (remain_ff == CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      held_wide                = 7'(count_in);
      rsp_word_in.entries_held = held_wide[SKVT_HELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("occupied cells disagree with entry count");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key held in more than one cell");

   a_bad_action_silent: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.action != ACT_INSERT && req_word.action != ACT_DELETE
      && req_word.action != ACT_SEARCH && req_word.action != ACT_EDIT
      && req_word.action != ACT_LIST |=> !rsp_strobe)
      else $error("result for an unknown action");

   a_list_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("list cycle without a result");

endmodule
